// File: src/sgpg_pkg.sv
package sgpg_pkg;

    localparam int COLUMNS = 1024;
    localparam int ROWS    = 1024;

    localparam longint PI_Q30  = 64'sd3373259422;
    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint TAYLOR_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef enum logic [1:0] {
        MODE_DRIFT,
        MODE_COUNTER,
        MODE_STATIC_REV,
        MODE_STATIC
    } mode_t;

    typedef enum logic [1:0] {
        RGN_BLANK,
        RGN_GRATING,
        RGN_REVERSED,
        RGN_NONE
    } region_t;

    typedef enum logic [2:0] {
        CFG_MODE,
        CFG_FRAME_COUNTS,
        CFG_COL_STEP,
        CFG_ROW_STEP,
        CFG_TEMPORAL,
        CFG_CH_PHASES,
        CFG_CH_LEVELS,
        CFG_CH_AMPS
    } cfg_index_t;

    typedef struct packed {
        logic load_index;
        logic load_value;
    } cos_en_t;

    // Quarter-wave cosine in Q0.15 from an angle in Q30 radians
    function automatic logic [14:0] cos_q15(input longint x);
        longint x2;
        longint term;
        longint sum;
        longint v;
        x2 = (x * x) >>> 30;
        term = Q30_ONE;
        sum = term;
        for (int k = 1; k <= 8; k++)
        begin
            term = -((term * x2) / Q30_ONE);
            term = term / TAYLOR_DIV[k];
            sum = sum + term;
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32767)
        begin
            v = 64'sd32767;
        end
        return v[14:0];
    endfunction

endpackage

// File: src/sgpg_cos_lut.sv
module sgpg_cos_lut
    import sgpg_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int PW    = 16
)
(
    input  logic                clk,
    input  cos_en_t             en,
    input  logic [PW-1:0]       phase,
    output logic signed [15:0]  cosine
);

    localparam int QW = $clog2(4 * DEPTH);
    localparam int MW = PW + QW;
    localparam int AW = $clog2(DEPTH + 1);
    localparam logic [MW-1:0] SCALE = MW'(4 * DEPTH);
    localparam logic [QW-1:0] D1 = QW'(DEPTH);
    localparam logic [QW-1:0] D2 = QW'(2 * DEPTH);
    localparam logic [QW-1:0] D3 = QW'(3 * DEPTH);
    localparam logic [QW-1:0] DQ = QW'(DEPTH);

    logic [14:0]   rom [0:DEPTH];
    logic [MW-1:0] prod;
    logic [QW-1:0] q;
    logic [QW-1:0] r;
    logic [1:0]    quad;
    logic [AW-1:0] idx_next;
    logic          neg_next;
    logic [AW-1:0] idx_reg;
    logic          neg_a_reg;
    logic [14:0]   mag_reg;
    logic          neg_b_reg;

    for (genvar i = 0; i <= DEPTH; i++)
    begin : g_rom
        localparam longint X = (PI_Q30 * longint'(i)) / longint'(2 * DEPTH);
        assign rom[i] = cos_q15(X);
    end

    assign prod = MW'(phase) * SCALE;
    assign q    = prod[MW-1:PW];

    always_comb
    begin
        if (q >= D3)
        begin
            quad = 2'd3;
            r = q - D3;
        end
        else if (q >= D2)
        begin
            quad = 2'd2;
            r = q - D2;
        end
        else if (q >= D1)
        begin
            quad = 2'd1;
            r = q - D1;
        end
        else
        begin
            quad = 2'd0;
            r = q;
        end
        idx_next = quad[0] ? AW'(DQ - r) : AW'(r);
        neg_next = quad[0] ^ quad[1];
    end

    always_ff @(posedge clk)
    begin
        if (en.load_index)
        begin
            idx_reg   <= idx_next;
            neg_a_reg <= neg_next;
        end
        if (en.load_value)
        begin
            mag_reg   <= rom[idx_reg];
            neg_b_reg <= neg_a_reg;
        end
    end

    assign cosine = neg_b_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

// File: src/sinusoidal_grating_pixel_generator.sv
// Oriented sinusoidal grating generator: one pixel request (frame, column, row) in,
// one RGB result out, one pixel per clock while the output is not stalled, through a
// seven-stage pipeline (input multiplies, phase sums, cosine lookup index and read,
// temporal product, amplitude product, final rounding and level add). Four copies
// of the quarter-wave cosine ROM, one per colour channel plus one for the temporal
// term, each give one registered read per cycle while their stage advances. Each
// stage holds its item while the next stage is full and stalled, so a stall on the
// output loses nothing and bubbles close up. Configuration writes take effect at
// once, so write only while no pixel is in flight.
module sinusoidal_grating_pixel_generator
    import sgpg_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frame[15:0], column[25:16], row[35:26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red[17:0], green[35:18], blue[53:36]
    output logic        m_tuser,   // updated
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int PW = PHASE_BITS;
    localparam int NS = 7;

    function automatic logic [PW-1:0] align16(input logic [15:0] v);
        logic [PW+15:0] w;
        w = {v, {PW{1'b0}}};
        return w[PW+15:16];
    endfunction

    mode_t       mode_reg;
    logic [47:0] counts_reg;
    logic [15:0] col_step_reg;   // only the low bits of cfg_data are kept
    logic [15:0] row_step_reg;
    logic [31:0] temporal_reg;
    logic [47:0] ch_phase_reg;
    logic [47:0] ch_level_reg;
    logic [47:0] ch_amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STATIC_REV;
            counts_reg   <= '0;
            col_step_reg <= '0;
            row_step_reg <= '0;
            temporal_reg <= '0;
            ch_phase_reg <= '0;
            ch_level_reg <= '0;
            ch_amp_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:         mode_reg     <= mode_t'(cfg_data[1:0]);
                CFG_FRAME_COUNTS: counts_reg   <= cfg_data;
                CFG_COL_STEP:     col_step_reg <= cfg_data[15:0];
                CFG_ROW_STEP:     row_step_reg <= cfg_data[15:0];
                CFG_TEMPORAL:     temporal_reg <= cfg_data[31:0];
                CFG_CH_PHASES:    ch_phase_reg <= cfg_data;
                CFG_CH_LEVELS:    ch_level_reg <= cfg_data;
                CFG_CH_AMPS:      ch_amp_reg   <= cfg_data;
                default:          mode_reg     <= mode_reg;
            endcase
        end
    end

    logic [NS:1] valid_reg;
    logic [NS:1] valid_next;
    logic [NS:1] adv;

    always_comb
    begin
        adv[NS] = !valid_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[1] = adv[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= NS; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[1];

    // Stage 1: coordinate and frame products, interval decode
    logic [15:0] in_frame;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] sx_next;
    logic [15:0] sy_next;
    logic [15:0] ft_next;
    logic [16:0] end_grating;
    logic [17:0] end_reversed;
    logic [15:0] n_reversed;
    region_t     rgn_next;

    assign in_frame   = s_tdata[15:0];
    assign dx         = 16'(s_tdata[25:16]) - 16'(COLUMNS / 2);
    assign dy         = 16'(s_tdata[35:26]) - 16'(ROWS / 2);
    assign sx_next    = 16'(dx * col_step_reg);
    assign sy_next    = 16'(dy * row_step_reg);
    assign ft_next    = 16'(temporal_reg[15:0] * in_frame);
    assign n_reversed = (mode_reg == MODE_STATIC_REV) ? counts_reg[47:32] : 16'd0;
    assign end_grating  = 17'(counts_reg[15:0]) + 17'(counts_reg[31:16]);
    assign end_reversed = 18'(end_grating) + 18'(n_reversed);

    always_comb
    begin
        if (in_frame < counts_reg[15:0])
        begin
            rgn_next = RGN_BLANK;
        end
        else if (17'(in_frame) < end_grating)
        begin
            rgn_next = RGN_GRATING;
        end
        else if (18'(in_frame) < end_reversed)
        begin
            rgn_next = RGN_REVERSED;
        end
        else
        begin
            rgn_next = RGN_NONE;
        end
    end

    logic [15:0] sx_reg;
    logic [15:0] sy_reg;
    logic [15:0] ft_reg;
    region_t     rgn1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            ft_reg   <= ft_next;
            rgn1_reg <= rgn_next;
        end
    end

    // Stage 2: phase words per channel and for the temporal term
    logic [PW-1:0] spat;
    logic [PW-1:0] drift;
    logic [PW-1:0] ph_next [3];
    logic [PW-1:0] tph_next;

    assign spat  = align16(sx_reg + sy_reg);
    assign drift = (rgn1_reg == RGN_GRATING && mode_reg == MODE_DRIFT)
                   ? align16(ft_reg) : '0;
    assign tph_next = align16(ft_reg + temporal_reg[31:16]);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ph_next[k] = spat + align16(ch_phase_reg[16*k +: 16]) - drift;
        end
    end

    logic [PW-1:0] ph_reg [3];
    logic [PW-1:0] tph_reg;
    region_t       rgn2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_reg[k] <= ph_next[k];
            end
            tph_reg  <= tph_next;
            rgn2_reg <= rgn1_reg;
        end
    end

    // Stages 3 and 4: cosine lookup
    cos_en_t            cos_en;
    logic signed [15:0] cos_ch [3];
    logic signed [15:0] cos_t;

    assign cos_en.load_index = adv[3];
    assign cos_en.load_value = adv[4];

    for (genvar g = 0; g < 3; g++)
    begin : g_ch_cos
        sgpg_cos_lut #(
            .DEPTH (COS_TABLE_DEPTH),
            .PW    (PW)
        ) u_cos (
            .clk    (clk),
            .en     (cos_en),
            .phase  (ph_reg[g]),
            .cosine (cos_ch[g])
        );
    end

    sgpg_cos_lut #(
        .DEPTH (COS_TABLE_DEPTH),
        .PW    (PW)
    ) u_cos_t (
        .clk    (clk),
        .en     (cos_en),
        .phase  (tph_reg),
        .cosine (cos_t)
    );

    region_t rgn3_reg;
    region_t rgn4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            rgn3_reg <= rgn2_reg;
        end
        if (adv[4])
        begin
            rgn4_reg <= rgn3_reg;
        end
    end

    // Stage 5: temporal product
    logic signed [31:0] tprod_reg [3];
    logic signed [15:0] cs5_reg [3];
    region_t            rgn5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int k = 0; k < 3; k++)
            begin
                tprod_reg[k] <= cos_ch[k] * cos_t;
                cs5_reg[k]   <= cos_ch[k];
            end
            rgn5_reg <= rgn4_reg;
        end
    end

    // Stage 6: amplitude product
    logic               counter_sel;
    logic signed [31:0] tround [3];
    logic signed [15:0] c6 [3];
    logic signed [32:0] aprod_next [3];

    assign counter_sel = (rgn5_reg == RGN_GRATING) && (mode_reg == MODE_COUNTER);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tround[k]     = (tprod_reg[k] + 32'sd16384) >>> 15;
            c6[k]         = counter_sel ? tround[k][15:0] : cs5_reg[k];
            aprod_next[k] = $signed({1'b0, ch_amp_reg[16*k +: 16]}) * c6[k];
        end
    end

    logic signed [32:0] aprod_reg [3];
    region_t            rgn6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int k = 0; k < 3; k++)
            begin
                aprod_reg[k] <= aprod_next[k];
            end
            rgn6_reg <= rgn5_reg;
        end
    end

    // Stage 7: round, then add to or subtract from the mean level
    logic signed [32:0] term_full [3];
    logic signed [17:0] term [3];
    logic signed [17:0] lvl [3];
    logic signed [17:0] pix_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            term_full[k] = (aprod_reg[k] + 33'sd16384) >>> 15;
            term[k]      = term_full[k][17:0];
            lvl[k]       = $signed({2'b00, ch_level_reg[16*k +: 16]});
            case (rgn6_reg)
                RGN_BLANK:    pix_next[k] = lvl[k];
                RGN_GRATING:  pix_next[k] = lvl[k] + term[k];
                RGN_REVERSED: pix_next[k] = lvl[k] - term[k];
                default:      pix_next[k] = '0;
            endcase
        end
    end

    logic signed [17:0] pix_reg [3];
    logic               updated_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pix_reg[k] <= pix_next[k];
            end
            updated_reg <= (rgn6_reg != RGN_NONE);
        end
    end

    assign m_tvalid = valid_reg[NS];
    assign m_tdata  = {2'b00, pix_reg[2], pix_reg[1], pix_reg[0]};
    assign m_tuser  = updated_reg;

    a_keep_frame_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("pixel outside every interval carries nonzero colour");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> s_tready)
        else $error("empty pipeline refuses a transfer");

endmodule

// File: bench/tb_sinusoidal_grating_pixel_generator.sv
module tb_sinusoidal_grating_pixel_generator;
    import sgpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COS_DEPTH = 1024;
    localparam int PHASE_W = 16;
    localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_W) - 1;
    localparam longint ANGLE_PI_Q30 = 64'sd3373259422;
    localparam int RANDOM_PHASES = 12;
    localparam int PIXELS_PER_PHASE = 150;
    localparam int QUIET_PHASES = 3;

    typedef struct packed {
        logic signed [17:0] red;
        logic signed [17:0] green;
        logic signed [17:0] blue;
        logic updated;
    } pixel_rgb_t;

    typedef struct {
        mode_t mode;
        logic [47:0] counts;
        logic [31:0] col_step;
        logic [31:0] row_step;
        logic [31:0] temporal;
        logic [47:0] phases;
        logic [47:0] levels;
        logic [47:0] amps;
    } grating_setup_t;

    typedef struct packed {
        logic [2:0] setup_sel;
        logic [15:0] frame;
        logic [9:0] col;
        logic [9:0] row;
        logic known;
        pixel_rgb_t pixel;
    } pixel_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [39:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [55:0] m_tdata;
    logic m_tuser;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [47:0] cfg_data;

    longint quarter_cos [0:COS_DEPTH];
    grating_setup_t active_setup;
    grating_setup_t directed_setups [0:4];
    pixel_row_t directed_rows [0:21];
    pixel_rgb_t expected_pixels [$];
    pixel_rgb_t typed_pixel;
    bit use_typed;
    bit idle_on;
    int error_count;

    sinusoidal_grating_pixel_generator #(
        .COS_TABLE_DEPTH(COS_DEPTH),
        .PHASE_BITS(PHASE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void fill_quarter_cos();
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        for (int i = 0; i <= COS_DEPTH; i++)
        begin
            x = (ANGLE_PI_Q30 * i) / (2 * COS_DEPTH);
            x2 = (x * x) >>> 30;
            term = 64'sd1 << 30;
            sum = term;
            for (int k = 1; k <= 8; k++)
            begin
                term = -((term * x2) / (64'sd1 << 30));
                term = term / ((2 * k - 1) * (2 * k));
                sum = sum + term;
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (sum + 64'sd16384) >>> 15;
            if (v > 64'sd32767)
            begin
                v = 64'sd32767;
            end
            quarter_cos[i] = v;
        end
    endfunction

    function automatic longint unsigned phase_of16(longint unsigned v);
        longint unsigned w;
        w = v & 64'hFFFF;
        if (PHASE_W >= 16)
        begin
            w = w << (PHASE_W - 16);
        end
        else
        begin
            w = w >> (16 - PHASE_W);
        end
        return w & PHASE_MASK;
    endfunction

    function automatic longint cos_at(longint unsigned p);
        longint unsigned q;
        longint unsigned quad;
        int r;
        q = ((p & PHASE_MASK) * 4 * COS_DEPTH) >> PHASE_W;
        quad = q / COS_DEPTH;
        r = int'(q % COS_DEPTH);
        case (quad & 3)
            0: return quarter_cos[r];
            1: return -quarter_cos[COS_DEPTH - r];
            2: return -quarter_cos[r];
            default: return quarter_cos[COS_DEPTH - r];
        endcase
    endfunction

    function automatic pixel_rgb_t grating_pixel(logic [15:0] t, logic [9:0] col,
                                                 logic [9:0] rw);
        pixel_rgb_t px;
        region_t rgn;
        longint nb;
        longint ng;
        longint nr;
        longint unsigned drift;
        longint unsigned spat;
        longint unsigned p;
        longint lvl;
        longint amp;
        longint c;
        longint term;
        longint v;
        logic [17:0] ch [0:2];
        nb = active_setup.counts[15:0];
        ng = active_setup.counts[31:16];
        nr = (active_setup.mode == MODE_STATIC_REV) ? active_setup.counts[47:32] : 0;
        drift = longint'(active_setup.temporal[15:0]) * longint'(t);
        spat = phase_of16((longint'(col) - COLUMNS / 2)
                          * longint'(signed'(active_setup.col_step))
                          + (longint'(rw) - ROWS / 2)
                          * longint'(signed'(active_setup.row_step)));
        if (t < nb)
            rgn = RGN_BLANK;
        else if (t < nb + ng)
            rgn = RGN_GRATING;
        else if (t < nb + ng + nr)
            rgn = RGN_REVERSED;
        else
            rgn = RGN_NONE;
        for (int k = 0; k < 3; k++)
        begin
            lvl = active_setup.levels[16 * k +: 16];
            amp = active_setup.amps[16 * k +: 16];
            p = spat + phase_of16(active_setup.phases[16 * k +: 16]);
            v = 0;
            if (rgn == RGN_BLANK)
            begin
                v = lvl;
            end
            else if (rgn != RGN_NONE)
            begin
                if (rgn == RGN_GRATING && active_setup.mode == MODE_DRIFT)
                begin
                    p = p - phase_of16(drift);
                end
                c = cos_at(p);
                if (rgn == RGN_GRATING && active_setup.mode == MODE_COUNTER)
                begin
                    c = (c * cos_at(phase_of16(drift + active_setup.temporal[31:16]))
                         + 64'sd16384) >>> 15;
                end
                term = (amp * c + 64'sd16384) >>> 15;
                v = (rgn == RGN_REVERSED) ? lvl - term : lvl + term;
            end
            ch[k] = v[17:0];
        end
        px.red = ch[0];
        px.green = ch[1];
        px.blue = ch[2];
        px.updated = (rgn != RGN_NONE);
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [17:0] got,
                               input logic [17:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got 0x%05h expected 0x%05h", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        pixel_rgb_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_pixels.push_back(use_typed ? typed_pixel
                    : grating_pixel(s_tdata[15:0], s_tdata[25:16], s_tdata[35:26]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("result transfer with no pending request");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", m_tdata[17:0], want.red);
                    check_field("green", m_tdata[35:18], want.green);
                    check_field("blue", m_tdata[53:36], want.blue);
                    check_field("updated", {17'b0, m_tuser}, {17'b0, want.updated});
                end
            end
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall == 0 && idle_on && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 6);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [15:0] t, input logic [9:0] col,
                              input logic [9:0] rw, input bit known,
                              input pixel_rgb_t px);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        use_typed = known;
        typed_pixel = px;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, rw, col, t};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic apply_setup(input grating_setup_t s);
        cfg_index_t idx;
        logic [47:0] value;
        for (int i = 0; i < 8; i++)
        begin
            idx = cfg_index_t'(i);
            case (idx)
                CFG_MODE: value = 48'(s.mode);
                CFG_FRAME_COUNTS: value = s.counts;
                CFG_COL_STEP: value = 48'(s.col_step);
                CFG_ROW_STEP: value = 48'(s.row_step);
                CFG_TEMPORAL: value = 48'(s.temporal);
                CFG_CH_PHASES: value = s.phases;
                CFG_CH_LEVELS: value = s.levels;
                default: value = s.amps;
            endcase
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        active_setup = s;
    endtask

    function automatic logic [15:0] random_count();
        return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    endfunction

    function automatic logic [31:0] random_step();
        return ($urandom_range(0, 2) == 0) ? 32'($urandom)
            : 32'($urandom_range(0, 8191)) - 32'd4096;
    endfunction

    function automatic grating_setup_t random_setup();
        grating_setup_t s;
        s.mode = mode_t'($urandom_range(0, 3));
        s.counts = {random_count(), random_count(), random_count()};
        s.col_step = random_step();
        s.row_step = random_step();
        s.temporal = $urandom;
        s.phases = {16'($urandom), 32'($urandom)};
        s.levels = {16'($urandom), 32'($urandom)};
        s.amps = {16'($urandom), 32'($urandom)};
        return s;
    endfunction

    function automatic logic [15:0] random_frame();
        int span;
        span = active_setup.counts[15:0] + active_setup.counts[31:16]
             + active_setup.counts[47:32] + 4;
        if (span > 65535)
        begin
            span = 65535;
        end
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
    endfunction

    initial
    begin
        int cur_setup;
        pixel_rgb_t none_px;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        use_typed = 1'b0;
        typed_pixel = '0;
        idle_on = 1'b1;
        error_count = 0;
        fill_quarter_cos();
        none_px = '0;

        active_setup = '{MODE_STATIC_REV, 48'h0, 32'h0, 32'h0, 32'h0, 48'h0, 48'h0, 48'h0};
        directed_setups[0] = active_setup;
        directed_setups[1] = '{MODE_STATIC_REV, 48'h0002_0003_0002, 32'h0000_1000,
                               32'hFFFF_F000, 32'h4000_0100, 48'h8000_4000_0000,
                               48'hFFFF_4000_8000, 48'h7FFF_FFFF_0100};
        directed_setups[2] = '{MODE_DRIFT, 48'h0000_FFFF_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_1234, 48'hFFFF_FFFF_FFFF,
                               48'h0, 48'hFFFF_FFFF_FFFF};
        directed_setups[3] = '{MODE_COUNTER, 48'hFFFF_0010_0001, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'h0,
                               48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
        directed_setups[4] = '{MODE_STATIC, 48'h0005_0001_0000, 32'h0, 32'h0001_0000,
                               32'h0, 48'h0000_0000_4000, 48'h0100_0100_0100,
                               48'h0080_0080_0080};

        directed_rows = '{
            '{3'd0, 16'd0, 10'd0, 10'd0, 1'b1, none_px},
            '{3'd0, 16'd65535, 10'd1023, 10'd1023, 1'b1, none_px},
            '{3'd0, 16'd100, 10'd512, 10'd512, 1'b1, none_px},
            '{3'd1, 16'd0, 10'd0, 10'd0, 1'b1,
              pixel_rgb_t'{18'h08000, 18'h04000, 18'h0FFFF, 1'b1}},
            '{3'd1, 16'd1, 10'd1023, 10'd1023, 1'b1,
              pixel_rgb_t'{18'h08000, 18'h04000, 18'h0FFFF, 1'b1}},
            '{3'd1, 16'd2, 10'd512, 10'd512, 1'b0, none_px},
            '{3'd1, 16'd4, 10'd0, 10'd1023, 1'b0, none_px},
            '{3'd1, 16'd5, 10'd1023, 10'd0, 1'b0, none_px},
            '{3'd1, 16'd6, 10'd300, 10'd700, 1'b0, none_px},
            '{3'd1, 16'd7, 10'd1, 10'd2, 1'b1, none_px},
            '{3'd1, 16'd65535, 10'd1023, 10'd1023, 1'b1, none_px},
            '{3'd2, 16'd0, 10'd0, 10'd0, 1'b0, none_px},
            '{3'd2, 16'd1, 10'd1023, 10'd1023, 1'b0, none_px},
            '{3'd2, 16'd65534, 10'd511, 10'd513, 1'b0, none_px},
            '{3'd2, 16'd65535, 10'd0, 10'd0, 1'b1, none_px},
            '{3'd3, 16'd0, 10'd0, 10'd0, 1'b1,
              pixel_rgb_t'{18'h0FFFF, 18'h0FFFF, 18'h0FFFF, 1'b1}},
            '{3'd3, 16'd1, 10'd1023, 10'd0, 1'b0, none_px},
            '{3'd3, 16'd16, 10'd0, 10'd1023, 1'b0, none_px},
            '{3'd3, 16'd17, 10'd512, 10'd512, 1'b1, none_px},
            '{3'd4, 16'd0, 10'd100, 10'd900, 1'b0, none_px},
            '{3'd4, 16'd1, 10'd0, 10'd0, 1'b1, none_px},
            '{3'd4, 16'd3, 10'd1023, 10'd1023, 1'b1, none_px}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cur_setup = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].setup_sel != cur_setup)
            begin
                cur_setup = directed_rows[i].setup_sel;
                wait_drained();
                apply_setup(directed_setups[cur_setup]);
            end
            send_pixel(directed_rows[i].frame, directed_rows[i].col, directed_rows[i].row,
                       directed_rows[i].known, directed_rows[i].pixel);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            apply_setup(random_setup());
            idle_on = (ph < RANDOM_PHASES - QUIET_PHASES);
            repeat (PIXELS_PER_PHASE)
            begin
                send_pixel(random_frame(), 10'($urandom), 10'($urandom), 1'b0, none_px);
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
src/sgpg_pkg.sv
src/sgpg_cos_lut.sv
src/sinusoidal_grating_pixel_generator.sv
bench/tb_sinusoidal_grating_pixel_generator.sv
